>>> src/lsspj_pkg.sv
// Shared types and constants for the list suffix-sum block.
package lsspj_pkg;

	localparam int WEIGHT_W = 8;
	localparam int LINK_W   = 6;
	localparam int SUM_W    = 16;

	// One list element as it arrives on the input channel.
	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic [LINK_W-1:0]          next_index;
		logic                       last_element;
	} in_item_t;

	// One suffix-sum result on the output channel.
	typedef struct packed {
		logic signed [SUM_W-1:0] suffix_sum;
		logic                    final_result;
	} out_item_t;

	// One entry of a working bank: running sum and current successor.
	typedef struct packed {
		logic [SUM_W-1:0]  value;
		logic [LINK_W-1:0] link;
	} entry_t;

	// Control phases of the block.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_JUMP,
		ST_EMIT
	} state_t;

endpackage

>>> src/lsspj_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
interface lsspj_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> src/list_suffix_sum_pointer_jumping_top.sv
// List suffix sums by pointer jumping over two ping-pong element banks.
// Loading writes each accepted item into both banks. After the last item, each jumping round
// streams all N elements through a three-stage read/read/write pipeline, for ceil(log2(N))
// rounds; the emit pass then keeps one read in flight, issuing the next only when the
// output register will be free.
// Reset clears all control state; the banks are not cleared and hold no valid bits.
module list_suffix_sum_pointer_jumping_top #(
	parameter int MAX_ELEMENTS = 64
) (
	input logic clk,
	input logic arst_n,
	lsspj_stream_if.sink   elems,
	lsspj_stream_if.source sums
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

	// Smallest r with 2^r >= n.
	function automatic logic [2:0] rounds_for(input logic [CNT_W-1:0] n);
		logic [2:0] r;
		r = '0;
		for (int k = 0; k < 7; k++) begin
			if ((1 << k) < int'(n)) begin
				r = 3'(k + 1);
			end
		end
		return r;
	endfunction

	lsspj_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] load_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       rounds_q;
	logic [2:0]       round_q;
	logic             src_q;
	logic [CNT_W-1:0] iss_idx_q;
	logic [CNT_W-1:0] emit_idx_q;
	logic             pend_q;
	logic             out_valid_q;
	lsspj_pkg::out_item_t out_item_q;

	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             v_s2;
	logic [IDX_W-1:0] idx_s2;
	lsspj_pkg::entry_t ent_s2;
	logic             self_s2;

	logic                      we0, we1;
	logic [IDX_W-1:0]          waddr;
	lsspj_pkg::entry_t         wdata;
	logic [IDX_W-1:0]          raddr_a, raddr_b;
	lsspj_pkg::entry_t         rd0_a, rd0_b, rd1_a, rd1_b;
	lsspj_pkg::entry_t         a_data, b_data;
	lsspj_pkg::entry_t         jump_entry;
	lsspj_pkg::entry_t         load_entry;

	logic             in_acc, out_acc;
	logic             load_last;
	logic [CNT_W-1:0] load_cnt;
	logic [2:0]       load_rounds;
	logic             iss_go, round_end, last_round;
	logic             emit_go, emit_done;
	logic             self_s1;

	// Handshakes.
	assign in_acc  = elems.valid && elems.ready;
	assign out_acc = sums.valid && sums.ready;
	assign elems.ready  = (state_q == lsspj_pkg::ST_LOAD);
	assign sums.valid   = out_valid_q;
	assign sums.payload = out_item_q;

	// Load: the item at the last store address always closes the list.
	assign load_cnt    = load_idx_q + CNT_W'(1);
	assign load_last   = in_acc &&
		(elems.payload.last_element || (load_idx_q == CNT_MAX - CNT_W'(1)));
	assign load_rounds = rounds_for(load_cnt);

	// A successor outside the store ends the list at this element.
	always_comb begin
		load_entry.value = {{(lsspj_pkg::SUM_W - lsspj_pkg::WEIGHT_W)
			{elems.payload.weight[lsspj_pkg::WEIGHT_W-1]}}, elems.payload.weight};
		if (int'(elems.payload.next_index) >= MAX_ELEMENTS) begin
			load_entry.link = lsspj_pkg::LINK_W'(load_idx_q[IDX_W-1:0]);
		end else begin
			load_entry.link = elems.payload.next_index;
		end
	end

	// Read data comes from the bank that holds the current round's values.
	assign a_data = src_q ? rd1_a : rd0_a;
	assign b_data = src_q ? rd1_b : rd0_b;

	// Jumping pipeline: stage 0 reads element i, stage 1 reads its successor,
	// stage 2 writes the combined entry into the other bank.
	assign iss_go     = (state_q == lsspj_pkg::ST_JUMP) && (iss_idx_q < count_q);
	assign round_end  = (state_q == lsspj_pkg::ST_JUMP) && !iss_go && !v_s1 && !v_s2;
	assign last_round = ((round_q + 3'd1) == rounds_q);
	assign self_s1    = (a_data.link[IDX_W-1:0] == idx_s1);
	assign raddr_b    = a_data.link[IDX_W-1:0];

	always_comb begin
		if (self_s2) begin
			jump_entry = ent_s2;
		end else begin
			jump_entry.value = ent_s2.value + b_data.value;
			jump_entry.link  = b_data.link;
		end
	end

	// Emit: one read in flight, issued only when the output register will be free.
	assign emit_go   = (state_q == lsspj_pkg::ST_EMIT) && !pend_q &&
		(emit_idx_q < count_q) && (!out_valid_q || sums.ready);
	assign emit_done = pend_q && ((emit_idx_q + CNT_W'(1)) == count_q);

	assign raddr_a = (state_q == lsspj_pkg::ST_EMIT) ? emit_idx_q[IDX_W-1:0]
		: iss_idx_q[IDX_W-1:0];

	// Next state and bank write port selection.
	always_comb begin
		state_d = state_q;
		we0     = 1'b0;
		we1     = 1'b0;
		waddr   = '0;
		wdata   = load_entry;
		unique case (state_q)
			lsspj_pkg::ST_LOAD: begin
				// Both banks take the loaded element.
				waddr = load_idx_q[IDX_W-1:0];
				wdata = load_entry;
				we0   = in_acc;
				we1   = in_acc;
				if (load_last) begin
					state_d = (load_rounds == 3'd0) ? lsspj_pkg::ST_EMIT
						: lsspj_pkg::ST_JUMP;
				end
			end
			lsspj_pkg::ST_JUMP: begin
				waddr = idx_s2;
				wdata = jump_entry;
				we0   = v_s2 && src_q;
				we1   = v_s2 && !src_q;
				if (round_end && last_round) begin
					state_d = lsspj_pkg::ST_EMIT;
				end
			end
			lsspj_pkg::ST_EMIT: begin
				// Copy each final entry into the other bank so both agree afterward.
				waddr = emit_idx_q[IDX_W-1:0];
				wdata = a_data;
				we0   = pend_q && src_q;
				we1   = pend_q && !src_q;
				if (emit_done) begin
					state_d = lsspj_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = lsspj_pkg::ST_LOAD;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsspj_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q  <= '0;
			count_q     <= '0;
			rounds_q    <= '0;
			round_q     <= '0;
			src_q       <= 1'b0;
			iss_idx_q   <= '0;
			emit_idx_q  <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			// Loading and the start of a new run.
			if (in_acc) begin
				load_idx_q <= load_last ? '0 : load_cnt;
			end
			if (load_last) begin
				count_q    <= load_cnt;
				rounds_q   <= load_rounds;
				round_q    <= '0;
				src_q      <= 1'b0;
				iss_idx_q  <= '0;
				emit_idx_q <= '0;
			end

			// Jumping pipeline valids and round sequencing.
			v_s1 <= iss_go;
			v_s2 <= v_s1;
			if (iss_go) begin
				iss_idx_q <= iss_idx_q + CNT_W'(1);
			end
			if (round_end) begin
				round_q   <= round_q + 3'd1;
				src_q     <= !src_q;
				iss_idx_q <= '0;
			end

			// Emit reads and the output register.
			if (emit_go) begin
				pend_q <= 1'b1;
			end
			if (pend_q) begin
				pend_q      <= 1'b0;
				emit_idx_q  <= emit_idx_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pipeline and output payload registers.
	always_ff @(posedge clk) begin
		idx_s1  <= iss_idx_q[IDX_W-1:0];
		idx_s2  <= idx_s1;
		ent_s2  <= a_data;
		self_s2 <= self_s1;
		if (pend_q) begin
			out_item_q.suffix_sum   <= a_data.value;
			out_item_q.final_result <= ((emit_idx_q + CNT_W'(1)) == count_q);
		end
	end

	// Ping-pong element banks.
	lsspj_bank #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (IDX_W)
	) u_bank0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd0_a),
		.rdata_b (rd0_b)
	);

	lsspj_bank #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (IDX_W)
	) u_bank1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd1_a),
		.rdata_b (rd1_b)
	);

endmodule

>>> src/lsspj_bank.sv
// One working bank: a memory with one write port and two registered read ports.
module lsspj_bank #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  lsspj_pkg::entry_t   wdata,
	input  logic [AW-1:0]       raddr_a,
	input  logic [AW-1:0]       raddr_b,
	output lsspj_pkg::entry_t   rdata_a,
	output lsspj_pkg::entry_t   rdata_b
);

	lsspj_pkg::entry_t mem [DEPTH];

	// Synchronous write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Both reads are registered, returning data in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
